// ===== rtl/core/i2cmw_pkg.sv =====
// i2cmw_pkg: shared types and constants for the i2c master write sequencer
// command codes, input beat and result beat layouts; no dependencies

package i2cmw_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [7:0] BYTE_MSB = 8'h80;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] address;
        logic       read_flag;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_level;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       byte_request;
        logic       busy_res;
        logic       done_res;
        logic [7:0] bytes_written;
    } res_item_t;

endpackage

// ===== rtl/core/i2cmw_cmd_if.sv =====
// i2cmw_cmd_if: valid/ready channel carrying command beats
// depends on i2cmw_pkg

interface i2cmw_cmd_if;
    logic                  valid;
    logic                  ready;
    i2cmw_pkg::cmd_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/i2cmw_res_if.sv =====
// i2cmw_res_if: valid/ready channel carrying result beats
// depends on i2cmw_pkg

interface i2cmw_res_if;
    logic                  valid;
    logic                  ready;
    i2cmw_pkg::res_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/i2cmw_seq.sv =====
// i2cmw_seq: pin phase state machine, one command beat per step_en
// depends on i2cmw_pkg

module i2cmw_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  i2cmw_pkg::cmd_item_t  item,
    output i2cmw_pkg::res_item_t  result
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_S1    = 4'd1,
        PH_S2    = 4'd2,
        PH_BDRV  = 4'd3,
        PH_BHIGH = 4'd4,
        PH_BLOW  = 4'd5,
        PH_AREL  = 4'd6,
        PH_ASAMP = 4'd7,
        PH_ASDA  = 4'd8,
        PH_WAIT  = 4'd9,
        PH_P1    = 4'd10,
        PH_P2    = 4'd11,
        PH_P3    = 4'd12
    } phase_t;

    phase_t     phase_reg, phase_next, phase_cur;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] total_reg, total_next;
    logic       ack_ok_reg, ack_ok_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       done;
    logic [7:0] count;

    always_comb
    begin
        phase_cur = (phase_reg > PH_P3) ? PH_IDLE : phase_reg;
    end

    always_comb
    begin
        phase_next      = phase_cur;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        total_next      = total_reg;
        ack_ok_next     = ack_ok_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        done            = 1'b0;
        count           = 8'd0;
        case (item.cmd)
            i2cmw_pkg::CMD_TICK:
            begin
                case (phase_cur)
                    PH_S1:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_S2;
                    end
                    PH_S2:
                    begin
                        scl_next       = 1'b1;
                        bit_index_next = 3'd0;
                        phase_next     = PH_BDRV;
                    end
                    PH_BDRV:
                    begin
                        sda_next   = ~|(shift_reg & i2cmw_pkg::BYTE_MSB);
                        phase_next = PH_BHIGH;
                    end
                    PH_BHIGH:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_BLOW;
                    end
                    PH_BLOW:
                    begin
                        scl_next   = 1'b1;
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bit_index_reg == 3'd7)
                        begin
                            bit_index_next = 3'd0;
                            phase_next     = PH_AREL;
                        end
                        else
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_BDRV;
                        end
                    end
                    PH_AREL:
                    begin
                        sda_next   = 1'b0;
                        scl_next   = 1'b0;
                        phase_next = PH_ASAMP;
                    end
                    PH_ASAMP:
                    begin
                        ack_ok_next = ~item.sda_level;
                        scl_next    = 1'b1;
                        phase_next  = PH_ASDA;
                    end
                    PH_ASDA:
                    begin
                        sda_next = 1'b1;
                        if (ack_ok_reg && (bytes_left_reg != 8'd0))
                            phase_next = PH_WAIT;
                        else
                            phase_next = PH_P1;
                    end
                    PH_P1:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_P2;
                    end
                    PH_P2:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_P3;
                    end
                    PH_P3:
                    begin
                        sda_next   = 1'b0;
                        done       = 1'b1;
                        count      = ack_ok_reg ? total_reg : 8'd0;
                        phase_next = PH_IDLE;
                    end
                    PH_WAIT:
                    begin
                        phase_next = PH_WAIT;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            i2cmw_pkg::CMD_START:
            begin
                if (phase_cur == PH_IDLE)
                begin
                    shift_next      = item.address + {7'd0, item.read_flag};
                    bytes_left_next = item.byte_count;
                    total_next      = item.byte_count;
                    bit_index_next  = 3'd0;
                    ack_ok_next     = 1'b0;
                    phase_next      = PH_S1;
                end
            end
            i2cmw_pkg::CMD_DATA:
            begin
                if (phase_cur == PH_WAIT)
                begin
                    shift_next      = item.data_byte;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    bit_index_next  = 3'd0;
                    phase_next      = PH_BDRV;
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase
    end

    always_comb
    begin
        result.scl_drive_low = scl_next;
        result.sda_drive_low = sda_next;
        result.byte_request  = (phase_next == PH_WAIT);
        result.busy_res      = (phase_next != PH_IDLE);
        result.done_res      = done;
        result.bytes_written = count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= 3'd0;
            shift_reg      <= 8'd0;
            bytes_left_reg <= 8'd0;
            total_reg      <= 8'd0;
            ack_ok_reg     <= 1'b0;
            scl_reg        <= 1'b0;
            sda_reg        <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            total_reg      <= total_next;
            ack_ok_reg     <= ack_ok_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
        end
    end

endmodule

// ===== rtl/core/i2c_master_write_sequencer.sv =====
// i2c_master_write_sequencer: top level, input register, sequencer, result register
// depends on i2cmw_pkg, i2cmw_cmd_if, i2cmw_res_if, i2cmw_seq
//
// usage:
//   req carries command beats: tick (one pin phase), start (address, read
//   flag, byte count) or data (next byte while byte_request is high).
//   rsp carries exactly one result beat per command beat, in order: the
//   open-drain pin drives after the beat, byte_request, busy, and done with
//   the number of bytes written (0 after any nack).
//   a beat passes through the input register, then the sequencer's
//   combinational phase update, then the result register; one beat per cycle
//   is taken while rsp does not stall.
//   if rsp stalls, the input register still takes one more beat, then req
//   ready drops until the result register empties; no beat is lost.
//   reset (rst_n low, asynchronous) returns the sequencer to idle with both
//   lines released and empties both registers.

module i2c_master_write_sequencer
(
    input  logic         clk,
    input  logic         rst_n,
    i2cmw_cmd_if.sink    req,
    i2cmw_res_if.source  rsp
);

    logic                  in_valid_reg;
    i2cmw_pkg::cmd_item_t  in_item_reg;
    logic                  out_valid_reg;
    i2cmw_pkg::res_item_t  out_item_reg;
    i2cmw_pkg::res_item_t  step_result;
    logic                  advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    i2cmw_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            in_item_reg <= req.payload;
        if (advance)
            out_item_reg <= step_result;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

endmodule

// ===== tb/i2cmw_write_checker.sv =====
`timescale 1ns / 100ps
// i2cmw_write_checker: watches the command and result channels, predicts the pin
// drives, byte request, busy, done and bytes written for every accepted beat and compares them
// depends on i2cmw_pkg, i2cmw_cmd_if, i2cmw_res_if

module i2cmw_write_checker
(
    input  logic  clk,
    input  logic  rst_n,
    i2cmw_cmd_if  req,
    i2cmw_res_if  rsp,
    output int    fail_count,
    output int    pending
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_SDA,
        ST_START_SCL,
        ST_BIT_DRIVE,
        ST_BIT_RISE,
        ST_BIT_FALL,
        ST_ACK_RELEASE,
        ST_ACK_SAMPLE,
        ST_ACK_HOLD,
        ST_WAIT_BYTE,
        ST_STOP_SDA,
        ST_STOP_SCL,
        ST_STOP_RELEASE
    } seq_state_t;

    seq_state_t  state;
    logic [2:0]  bit_pos;
    logic [7:0]  shift_reg;
    logic [7:0]  bytes_remaining;
    logic [7:0]  bytes_total;
    logic        acked;
    logic        scl_low;
    logic        sda_low;

    i2cmw_pkg::res_item_t  pin_results_q[$];
    i2cmw_pkg::res_item_t  want;
    i2cmw_pkg::res_item_t  got;

    task automatic report_mismatch(input string note);
        $display("%0t: mismatch, %s", $time, note);
        fail_count++;
    endtask

    function automatic i2cmw_pkg::res_item_t advance_pins(input i2cmw_pkg::cmd_item_t beat);
        i2cmw_pkg::res_item_t  r;
        logic                  done;
        logic [7:0]            count;
        done  = 1'b0;
        count = 8'd0;
        case (beat.cmd)
            i2cmw_pkg::CMD_TICK:
            begin
                case (state)
                    ST_START_SDA:
                    begin
                        sda_low = 1'b1;
                        state   = ST_START_SCL;
                    end
                    ST_START_SCL:
                    begin
                        scl_low = 1'b1;
                        bit_pos = 3'd0;
                        state   = ST_BIT_DRIVE;
                    end
                    ST_BIT_DRIVE:
                    begin
                        sda_low = ((shift_reg & i2cmw_pkg::BYTE_MSB) == 8'd0);
                        state   = ST_BIT_RISE;
                    end
                    ST_BIT_RISE:
                    begin
                        scl_low = 1'b0;
                        state   = ST_BIT_FALL;
                    end
                    ST_BIT_FALL:
                    begin
                        scl_low   = 1'b1;
                        shift_reg = shift_reg << 1;
                        if (bit_pos == 3'd7)
                        begin
                            bit_pos = 3'd0;
                            state   = ST_ACK_RELEASE;
                        end
                        else
                        begin
                            bit_pos = bit_pos + 3'd1;
                            state   = ST_BIT_DRIVE;
                        end
                    end
                    ST_ACK_RELEASE:
                    begin
                        sda_low = 1'b0;
                        scl_low = 1'b0;
                        state   = ST_ACK_SAMPLE;
                    end
                    ST_ACK_SAMPLE:
                    begin
                        acked   = !beat.sda_level;
                        scl_low = 1'b1;
                        state   = ST_ACK_HOLD;
                    end
                    ST_ACK_HOLD:
                    begin
                        sda_low = 1'b1;
                        state   = (acked && bytes_remaining != 8'd0) ? ST_WAIT_BYTE
                                                                     : ST_STOP_SDA;
                    end
                    ST_STOP_SDA:
                    begin
                        sda_low = 1'b1;
                        state   = ST_STOP_SCL;
                    end
                    ST_STOP_SCL:
                    begin
                        scl_low = 1'b0;
                        state   = ST_STOP_RELEASE;
                    end
                    ST_STOP_RELEASE:
                    begin
                        sda_low = 1'b0;
                        done    = 1'b1;
                        count   = acked ? bytes_total : 8'd0;
                        state   = ST_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            i2cmw_pkg::CMD_START:
            begin
                if (state == ST_IDLE)
                begin
                    shift_reg       = beat.address + {7'd0, beat.read_flag};
                    bytes_remaining = beat.byte_count;
                    bytes_total     = beat.byte_count;
                    bit_pos         = 3'd0;
                    acked           = 1'b0;
                    state           = ST_START_SDA;
                end
            end
            i2cmw_pkg::CMD_DATA:
            begin
                if (state == ST_WAIT_BYTE)
                begin
                    shift_reg       = beat.data_byte;
                    bytes_remaining = bytes_remaining - 8'd1;
                    bit_pos         = 3'd0;
                    state           = ST_BIT_DRIVE;
                end
            end
            default:
            begin
            end
        endcase
        r.scl_drive_low = scl_low;
        r.sda_drive_low = sda_low;
        r.byte_request  = (state == ST_WAIT_BYTE);
        r.busy_res      = (state != ST_IDLE);
        r.done_res      = done;
        r.bytes_written = count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state           = ST_IDLE;
            bit_pos         = 3'd0;
            shift_reg       = 8'd0;
            bytes_remaining = 8'd0;
            bytes_total     = 8'd0;
            acked           = 1'b0;
            scl_low         = 1'b0;
            sda_low         = 1'b0;
            pin_results_q.delete();
            fail_count      = 0;
            pending         = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.payload;
                if (pin_results_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = pin_results_q.pop_front();
                    if (got.scl_drive_low !== want.scl_drive_low)
                        report_mismatch($sformatf("scl_drive_low got %b expected %b",
                                                  got.scl_drive_low, want.scl_drive_low));
                    if (got.sda_drive_low !== want.sda_drive_low)
                        report_mismatch($sformatf("sda_drive_low got %b expected %b",
                                                  got.sda_drive_low, want.sda_drive_low));
                    if (got.byte_request !== want.byte_request)
                        report_mismatch($sformatf("byte_request got %b expected %b",
                                                  got.byte_request, want.byte_request));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res got %b expected %b",
                                                  got.busy_res, want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res got %b expected %b",
                                                  got.done_res, want.done_res));
                    if (got.bytes_written !== want.bytes_written)
                        report_mismatch($sformatf("bytes_written got %0d expected %0d",
                                                  got.bytes_written, want.bytes_written));
                end
            end
            if (req.valid && req.ready)
                pin_results_q.push_back(advance_pins(req.payload));
            pending = pin_results_q.size();
        end
    end

endmodule

// ===== tb/tb_i2c_master_write_sequencer.sv =====
`timescale 1ns / 100ps
// tb_i2c_master_write_sequencer: clock, reset and command stimulus for the i2c
// master write sequencer, with random idling on both channels and the verdict
// depends on i2cmw_pkg, i2cmw_cmd_if, i2cmw_res_if, i2cmw_write_checker

module tb_i2c_master_write_sequencer;

    localparam int CLK_PERIOD     = 10;
    localparam int ITEM_TARGET    = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TICKS_PER_BYTE = 27;
    localparam int ACK_SLOT       = 25;
    localparam int DRAIN_CYCLES   = 10;

    logic clk = 1'b0;
    logic rst_n;
    int   check_fails;
    int   check_pending;
    int   useful_beats;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;

    i2cmw_cmd_if req_ch ();
    i2cmw_res_if rsp_ch ();

    i2c_master_write_sequencer DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    i2cmw_write_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (check_fails),
        .pending    (check_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic i2cmw_pkg::cmd_item_t rand_beat(input i2cmw_pkg::cmd_t c);
        i2cmw_pkg::cmd_item_t b;
        b.cmd        = c;
        b.address    = 8'($urandom);
        b.read_flag  = 1'($urandom);
        b.byte_count = 8'($urandom);
        b.data_byte  = 8'($urandom);
        b.sda_level  = 1'($urandom);
        return b;
    endfunction

    task automatic issue(input i2cmw_pkg::cmd_item_t beat, input bit counts);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= beat;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (counts)
            useful_beats++;
        if (useful_beats < ITEM_TARGET / 3)
        begin
            send_idle_pct  = 28;
            recv_stall_pct = 72;
        end
        else if (useful_beats < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct  = 72;
            recv_stall_pct = 28;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    // a beat the block must ignore in its present state
    task automatic stray_beat(input i2cmw_pkg::cmd_t live);
        i2cmw_pkg::cmd_t c;
        do
            c = i2cmw_pkg::cmd_t'($urandom_range(0, 3));
        while (c == live);
        issue(rand_beat(c), 1'b0);
    endtask

    task automatic pin_tick(input bit sda, input int noise_pct);
        i2cmw_pkg::cmd_item_t b;
        if ($urandom_range(0, 99) < noise_pct)
            stray_beat(i2cmw_pkg::CMD_TICK);
        b = rand_beat(i2cmw_pkg::CMD_TICK);
        b.sda_level = sda;
        issue(b, 1'b1);
    endtask

    // nack_at: byte that is not acknowledged, 0 for the address, -1 for none
    task automatic run_write(input logic [7:0] addr, input bit rd, input logic [7:0] cnt,
                             input int nack_at, input int noise_pct, input int data_val);
        i2cmw_pkg::cmd_item_t b;
        int                   n;
        b = rand_beat(i2cmw_pkg::CMD_START);
        b.address    = addr;
        b.read_flag  = rd;
        b.byte_count = cnt;
        issue(b, 1'b1);
        pin_tick(1'($urandom), noise_pct);
        pin_tick(1'($urandom), noise_pct);
        for (n = 0; ; n++)
        begin
            for (int k = 0; k < TICKS_PER_BYTE; k++)
                pin_tick((k == ACK_SLOT) ? (n == nack_at) : 1'($urandom), noise_pct);
            if (n == nack_at || n == int'(cnt))
                break;
            if ($urandom_range(0, 99) < noise_pct)
                stray_beat(i2cmw_pkg::CMD_DATA);
            b = rand_beat(i2cmw_pkg::CMD_DATA);
            if (data_val >= 0)
                b.data_byte = 8'(data_val);
            issue(b, 1'b1);
        end
        repeat (3)
            pin_tick(1'($urandom), noise_pct);
    endtask

    initial
    begin
        logic [7:0] cnt;
        int         nack_at;
        int         noise;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rst_n          = 1'b0;
        useful_beats   = 0;
        send_idle_pct  = 28;
        recv_stall_pct = 72;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle ignores unused, tick and data beats
        issue(rand_beat(i2cmw_pkg::CMD_NONE), 1'b0);
        issue(rand_beat(i2cmw_pkg::CMD_TICK), 1'b0);
        issue(rand_beat(i2cmw_pkg::CMD_DATA), 1'b0);
        // read flag wraps the address, zero byte count
        run_write(8'hFF, 1'b1, 8'd0, -1, 0, -1);
        // largest count aborted by a nack on the address
        run_write(8'h00, 1'b0, 8'hFF, 0, 0, -1);
        run_write(8'hA4, 1'b0, 8'd2, -1, 30, 8'hFF);
        run_write(8'h7E, 1'b0, 8'd1, -1, 0, 8'h00);
        // nack on a data byte
        run_write(8'h7F, 1'b1, 8'd1, 1, 0, 8'h5A);

        while (useful_beats < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                cnt     = 8'($urandom);
                nack_at = $urandom_range(0, 3);
            end
            else
            begin
                cnt     = 8'($urandom_range(0, 3));
                nack_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, int'(cnt)) : -1;
            end
            noise = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 4) : 20;
            run_write(8'($urandom), 1'($urandom), cnt, nack_at, noise, -1);
            repeat ($urandom_range(0, 2))
                stray_beat(i2cmw_pkg::CMD_START);
        end
        req_ch.valid <= 1'b0;

        while (check_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (check_fails == 0)
            $display("i2c_master_write_sequencer test passed");
        else
            $display("i2c_master_write_sequencer test failed");
        $finish;
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("i2c_master_write_sequencer test failed");
        $finish;
    end

endmodule
